/* rtl/ibp_pkg.sv */
// Shared definitions for the index bit packer: width mode codes,
// register indexes, port widths and default sizes. No dependencies.
`timescale 1ns / 1ps

package ibp_pkg;

  // width mode codes
  localparam logic [2:0] MODE_1BIT = 3'd0;
  localparam logic [2:0] MODE_2BIT = 3'd1;
  localparam logic [2:0] MODE_3BIT = 3'd2;
  localparam logic [2:0] MODE_4BIT = 3'd3;
  localparam logic [2:0] MODE_8BIT = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 8'd1;

  // port widths
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 3;
  localparam int VLEN_W     = 13;
  localparam int INDEX_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;

  // reset values and sizes
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_8BIT;
  localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd128;
  localparam int MAX_VECTOR_LENGTH_DEF = 4096;

endpackage

/* rtl/index_bit_packer_top.sv */
// Index bit packer top level: packs quantization indices into a byte stream.
// Depends on ibp_pkg for mode codes, register indexes and widths.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_index_value
// out      output     out_valid/out_stall  out_packed_byte, out_end_of_vector,
//                                          out_last_of_run
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An accepted index is packed into the accumulator; a completed byte or
// word is loaded into the output word register at the same clock edge.
// The output register sends one byte a cycle while out_stall is low, so
// 3-bit mode gives four bytes per completed word and a new word may load
// as the last byte leaves. in_stall is high while the output register still
// holds bytes beyond the one leaving this cycle. Reset (synchronous) empties
// the packer and loads the register defaults; cfg_ready is always high.

module index_bit_packer_top #(
  parameter int MAX_VECTOR_LENGTH = ibp_pkg::MAX_VECTOR_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ibp_pkg::INDEX_W-1:0]   in_index_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ibp_pkg::BYTE_W-1:0]    out_packed_byte,
  output logic                          out_end_of_vector,
  output logic                          out_last_of_run,
  // configuration port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ibp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ibp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W = $clog2(MAX_VECTOR_LENGTH + 1);
  localparam int LEN_W = (POS_W > ibp_pkg::VLEN_W) ? POS_W : ibp_pkg::VLEN_W;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_VECTOR_LENGTH);

  // registers
  logic [ibp_pkg::MODE_W-1:0] mode_r;
  logic [ibp_pkg::VLEN_W-1:0] vlen_r;
  logic [ibp_pkg::WORD_W-1:0] acc_r, acc_nxt;
  logic [3:0]                 slot_r, slot_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [ibp_pkg::WORD_W-1:0] obuf_r;
  logic [2:0]                 ocnt_r;
  logic                       oeov_r;

  logic       cfg_we, in_fire, out_fire, can_load;
  logic [3:0] bits, slots, slot_inc;
  logic [2:0] nbytes;
  logic [7:0] mask;
  logic [4:0] shamt;
  logic [ibp_pkg::WORD_W-1:0] acc_sum;
  logic [LEN_W-1:0] eff_len, pos_inc;
  logic       vec_end, flush;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && ((cfg_index == ibp_pkg::REG_WIDTH_MODE) ||
                                   (cfg_index == ibp_pkg::REG_VECTOR_LENGTH));
  assign out_valid = (ocnt_r != 3'd0);
  assign out_fire  = out_valid && !out_stall;
  assign can_load  = (ocnt_r == 3'd0) || ((ocnt_r == 3'd1) && !out_stall);
  assign in_stall  = !can_load;
  assign in_fire   = in_valid && !in_stall;

  // decode width mode
  always_comb begin
    unique case (mode_r)
      ibp_pkg::MODE_1BIT: begin bits = 4'd1; slots = 4'd8;  nbytes = 3'd1; end
      ibp_pkg::MODE_2BIT: begin bits = 4'd2; slots = 4'd4;  nbytes = 3'd1; end
      ibp_pkg::MODE_3BIT: begin bits = 4'd3; slots = 4'd10; nbytes = 3'd4; end
      ibp_pkg::MODE_4BIT: begin bits = 4'd4; slots = 4'd2;  nbytes = 3'd1; end
      ibp_pkg::MODE_8BIT: begin bits = 4'd8; slots = 4'd1;  nbytes = 3'd1; end
      default:            begin bits = 4'd0; slots = 4'd1;  nbytes = 3'd1; end
    endcase
  end

  // insert the masked index at its slot
  always_comb begin
    mask     = 8'((9'd1 << bits) - 9'd1);
    shamt    = 5'(slot_r) * 5'(bits);
    acc_sum  = acc_r | (ibp_pkg::WORD_W'(in_index_value & mask) << shamt);
    slot_inc = slot_r + 4'd1;
  end

  // effective vector length: zero acts as one, saturate at the maximum
  always_comb begin
    eff_len = LEN_W'(vlen_r);
    if (eff_len == '0) begin
      eff_len = LEN_W'(1);
    end
    if (eff_len > MaxLen) begin
      eff_len = MaxLen;
    end
    pos_inc = LEN_W'(pos_r) + LEN_W'(1);
    vec_end = (pos_inc >= eff_len);
    flush   = (slot_inc == slots) || vec_end;
  end

  // next packing state
  always_comb begin
    acc_nxt  = flush ? '0 : acc_sum;
    slot_nxt = flush ? 4'd0 : slot_inc;
    pos_nxt  = vec_end ? '0 : pos_inc[POS_W-1:0];
  end

  // configuration and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ibp_pkg::MODE_RESET;
      vlen_r <= ibp_pkg::VLEN_RESET;
      acc_r  <= '0;
      slot_r <= 4'd0;
      pos_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ibp_pkg::REG_WIDTH_MODE) begin
        mode_r <= cfg_data[ibp_pkg::MODE_W-1:0];
      end else begin
        vlen_r <= cfg_data[ibp_pkg::VLEN_W-1:0];
      end
      acc_r  <= '0;
      slot_r <= 4'd0;
      pos_r  <= '0;
    end else if (in_fire) begin
      acc_r  <= acc_nxt;
      slot_r <= slot_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // output word register: load a finished word, shift out one byte each time a byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 3'd0;
    end else if (in_fire && flush) begin
      ocnt_r <= nbytes;
    end else if (out_fire) begin
      ocnt_r <= ocnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && flush) begin
      obuf_r <= acc_sum;
      oeov_r <= vec_end;
    end else if (out_fire) begin
      obuf_r <= obuf_r >> ibp_pkg::BYTE_W;
    end
  end

  assign out_packed_byte   = obuf_r[ibp_pkg::BYTE_W-1:0];
  assign out_last_of_run   = (ocnt_r == 3'd1);
  assign out_end_of_vector = oeov_r && (ocnt_r == 3'd1);

  // checks
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && flush |-> (ocnt_r == 3'd0) || ((ocnt_r == 3'd1) && out_fire))
    else $error("output word overwritten before drained");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (slot_r == 4'd0) && (pos_r == '0) && (acc_r == '0))
    else $error("register write did not clear packing state");

  a_slot_below_slots: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_we |=> (slot_r < 4'd10))
    else $error("slot count ran past a word");

endmodule

/* verif/index_bit_packer_top_test.sv */
// Self-checking testbench for index_bit_packer_top: directed and random index
// streams in every width mode, byte results checked against a local predictor.
// Depends on ibp_pkg and the index_bit_packer_top RTL.
`timescale 1ns / 1ps

module index_bit_packer_top_test;
  import ibp_pkg::*;

  // width mode codes beyond the package set: all send a zero-valued byte per index
  localparam logic [MODE_W-1:0] MODE_UNSUP_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNSUP_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNSUP_7 = 3'd7;
  // register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFE;

  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              end_of_vector;
    logic              last_of_run;
  } packed_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [INDEX_W-1:0]    in_index_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_packed_byte;
  logic                  out_end_of_vector;
  logic                  out_last_of_run;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // stimulus and result stores
  logic [INDEX_W-1:0] pending_indices[$];
  packed_result_t     expected_bytes[$];
  int indices_queued = 0;
  int indices_accepted = 0;
  int mismatch_count = 0;
  int sender_idle_pct = 24;
  int receiver_stall_pct = 45;

  // predictor state and register copies
  logic [MODE_W-1:0] cur_mode;
  logic [VLEN_W-1:0] cur_length;
  logic [WORD_W-1:0] acc_bits;
  logic [3:0]        slots_held;
  int                vector_pos;

  index_bit_packer_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_index_value    (in_index_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_byte   (out_packed_byte),
    .out_end_of_vector (out_end_of_vector),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic record_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%t: %s", $realtime, what);
    end
  endtask

  // Pack one index into the open byte or word and queue the bytes it closes.
  function automatic void predict_packed_bytes(input logic [INDEX_W-1:0] index_value);
    int bits;
    int slots;
    int nbytes;
    int len;
    logic closes;
    logic [WORD_W-1:0] field;
    packed_result_t r;
    case (cur_mode)
      MODE_1BIT: begin bits = 1; slots = 8;  nbytes = 1; end
      MODE_2BIT: begin bits = 2; slots = 4;  nbytes = 1; end
      MODE_3BIT: begin bits = 3; slots = 10; nbytes = 4; end
      MODE_4BIT: begin bits = 4; slots = 2;  nbytes = 1; end
      MODE_8BIT: begin bits = 8; slots = 1;  nbytes = 1; end
      default:   begin bits = 0; slots = 1;  nbytes = 1; end
    endcase
    if (bits != 0 && slots_held < slots) begin
      field = WORD_W'(index_value) & ((32'd1 << bits) - 32'd1);
      acc_bits = acc_bits | (field << (slots_held * bits));
    end
    slots_held = slots_held + 4'd1;
    vector_pos++;
    // zero length acts as one, long lengths saturate
    len = (cur_length == '0) ? 1 : int'(cur_length);
    if (len > MAX_VECTOR_LENGTH_DEF) len = MAX_VECTOR_LENGTH_DEF;
    closes = (vector_pos >= len);
    if (slots_held < slots && !closes) return;
    for (int k = 0; k < nbytes; k++) begin
      r.packed_byte   = acc_bits[8*k +: 8];
      r.last_of_run   = (k == nbytes - 1);
      r.end_of_vector = (k == nbytes - 1) && closes;
      expected_bytes.push_back(r);
    end
    acc_bits = '0;
    slots_held = '0;
    if (closes) vector_pos = 0;
  endfunction

  // Driver: predict on acceptance, then load the next index or idle.
  always @(posedge clk) begin : drive_indices
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_packed_bytes(in_index_value);
        indices_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_indices.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_index_value <= pending_indices.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted byte against the oldest expectation.
  always @(posedge clk) begin : check_bytes
    packed_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          record_mismatch($sformatf("unexpected byte %02h eov=%0b last=%0b",
                                    out_packed_byte, out_end_of_vector, out_last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          if (out_packed_byte !== want.packed_byte ||
              out_end_of_vector !== want.end_of_vector ||
              out_last_of_run !== want.last_of_run) begin
            record_mismatch($sformatf(
              "byte mismatch: expected %02h eov=%0b last=%0b, got %02h eov=%0b last=%0b",
              want.packed_byte, want.end_of_vector, want.last_of_run,
              out_packed_byte, out_end_of_vector, out_last_of_run));
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic queue_index(input logic [INDEX_W-1:0] value);
    pending_indices.push_back(value);
    indices_queued++;
  endtask

  // Wait until every queued index is taken and every byte has come out.
  task automatic wait_for_idle();
    int guard = 0;
    while ((indices_accepted != indices_queued || expected_bytes.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (indices_accepted != indices_queued) begin
      record_mismatch($sformatf("%0d queued indices never taken",
                                indices_queued - indices_accepted));
    end
    if (expected_bytes.size() != 0) begin
      record_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      expected_bytes.delete();
    end
  endtask

  // Write one register and mirror the write in the predictor.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIDTH_MODE) cur_mode = data[MODE_W-1:0];
    else if (idx == REG_VECTOR_LENGTH) cur_length = data[VLEN_W-1:0];
    // a write to the mode or length register drops a partial byte, word or vector
    if (idx == REG_WIDTH_MODE || idx == REG_VECTOR_LENGTH) begin
      acc_bits = '0;
      slots_held = '0;
      vector_pos = 0;
    end
    cfg_valid <= 1'b0;
  endtask

  // Configure mode and length with random spare bits, then stream indices.
  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [VLEN_W-1:0] length,
                           input int count);
    wait_for_idle();
    write_register(REG_VECTOR_LENGTH, {3'($urandom_range(0, 7)), length});
    write_register(REG_WIDTH_MODE, {13'($urandom_range(0, 8191)), mode});
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       queue_index(8'h00);
        1:       queue_index(8'hFF);
        default: queue_index(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : stimulus
    cur_mode   = MODE_RESET;
    cur_length = VLEN_RESET;
    acc_bits   = '0;
    slots_held = '0;
    vector_pos = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: one byte per index
    queue_index(8'h00);
    queue_index(8'hFF);
    queue_index(8'h5A);
    wait_for_idle();

    // zero length acts as one: every index closes a word in 3-bit mode
    write_register(REG_VECTOR_LENGTH, 16'hE000);
    write_register(REG_WIDTH_MODE, {13'h1FFF, MODE_3BIT});
    queue_index(8'hFF);
    queue_index(8'h07);
    wait_for_idle();

    // 1-bit mode, short vector flushed as a padded byte
    write_register(REG_VECTOR_LENGTH, 16'd3);
    write_register(REG_WIDTH_MODE, {13'h0000, MODE_1BIT});
    queue_index(8'hFF);
    queue_index(8'hFE);
    queue_index(8'h01);
    wait_for_idle();

    // long length saturates; a write to a spare index keeps the open byte
    write_register(REG_VECTOR_LENGTH, 16'h1FFF);
    write_register(REG_WIDTH_MODE, {13'h0AAA, MODE_2BIT});
    queue_index(8'hFF);
    queue_index(8'h02);
    queue_index(8'h01);
    wait_for_idle();
    write_register(REG_UNUSED, 16'hFFFF);
    queue_index(8'hFE);
    wait_for_idle();

    // 4-bit mode; a mode write drops the half-filled byte
    write_register(REG_VECTOR_LENGTH, 16'd5);
    write_register(REG_WIDTH_MODE, {13'h1555, MODE_4BIT});
    queue_index(8'hF3);
    queue_index(8'h0C);
    queue_index(8'h0A);
    wait_for_idle();
    write_register(REG_WIDTH_MODE, {13'h1FFF, MODE_4BIT});

    // unsupported mode sends a zero-valued byte for each index
    write_register(REG_WIDTH_MODE, {13'h0000, MODE_UNSUP_5});
    queue_index(8'hFF);
    queue_index(8'h80);

    // random phases: sender light, receiver heavy
    sender_idle_pct = 24;
    receiver_stall_pct = 45;
    run_phase(MODE_1BIT, 13'd1, 38);
    run_phase(MODE_3BIT, 13'($urandom_range(1, 24)), 38);
    run_phase(MODE_2BIT, 13'd4096, 38);
    run_phase(MODE_UNSUP_6, 13'($urandom_range(1, 24)), 38);

    // swap the idling sides
    sender_idle_pct = 45;
    receiver_stall_pct = 24;
    run_phase(MODE_4BIT, 13'd8191, 38);
    run_phase(MODE_3BIT, 13'd4097, 38);
    run_phase(MODE_8BIT, 13'($urandom_range(1, 24)), 38);
    run_phase(MODE_UNSUP_7, 13'd1, 38);

    // full rate on both sides
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_phase(MODE_1BIT, 13'($urandom_range(1, 24)), 38);
    run_phase(MODE_3BIT, 13'($urandom_range(1, 24)), 38);
    run_phase(MODE_2BIT, 13'($urandom_range(1, 24)), 38);
    run_phase(MODE_4BIT, 13'($urandom_range(1, 24)), 38);
    wait_for_idle();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/ibp_pkg.sv
rtl/index_bit_packer_top.sv
verif/index_bit_packer_top_test.sv
